// File: rtl/room_dispatch_scheduler_unit_assert.svh
// ----------------------------------------------------------------------------
// room dispatch scheduler assertion macros
// shorthand for clocked implication checks with a synchronous reset
// ----------------------------------------------------------------------------
`ifndef ROOM_DISPATCH_SCHEDULER_UNIT_ASSERT_SVH
`define ROOM_DISPATCH_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication
`define RDS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rds check failed");

// next-cycle implication
`define RDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rds check failed");

`endif

// File: rtl/rds_pkg.sv
// ----------------------------------------------------------------------------
// rds_pkg
// sizes, field types and state codes of the room dispatch scheduler
// ----------------------------------------------------------------------------
package rds_pkg;

  localparam int ROOMS   = 16;
  localparam int ROOM_W  = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int NUM_W   = $clog2(ROOMS + 1);
  localparam int TIME_W  = 32;
  localparam int END_W   = 48;
  localparam int CNT_W   = 32;
  localparam int FIELD_ROOM_W = 4;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] ROOMS_RESET = CFG_W'(16);
  localparam logic [END_W-1:0] END_MAX     = '1;
  localparam logic [CNT_W-1:0] COUNT_MAX   = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// File: rtl/rds_if.sv
// ----------------------------------------------------------------------------
// rds request and result channels
// valid/ready channels carrying a booking request and its result
// ----------------------------------------------------------------------------
interface rds_req_if;
  logic                                valid;
  logic                                ready;
  logic [rds_pkg::TIME_W-1:0]          start_time;
  logic [rds_pkg::TIME_W-1:0]          end_time;

  modport source (output valid, output start_time, output end_time, input ready);
  modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

interface rds_res_if;
  logic                                valid;
  logic                                ready;
  logic [rds_pkg::FIELD_ROOM_W-1:0]    assigned_room;
  logic [rds_pkg::END_W-1:0]           actual_end;
  logic                                was_delayed;
  logic [rds_pkg::FIELD_ROOM_W-1:0]    most_booked_room;
  logic                                bad_request;

  modport source (output valid, output assigned_room, output actual_end,
                  output was_delayed, output most_booked_room, output bad_request,
                  input ready);
  modport sink   (input valid, input assigned_room, input actual_end,
                  input was_delayed, input most_booked_room, input bad_request,
                  output ready);
endinterface

// File: rtl/room_dispatch_scheduler_unit.sv
// ----------------------------------------------------------------------------
// room_dispatch_scheduler_unit
// assigns booking requests to rooms and tracks the most-booked room
// ----------------------------------------------------------------------------
// Each booking item is accepted in the idle state, the scan state walks the
// active rooms (rooms_in_use clamped to 1..16) through the single read port
// of the room table one room per cycle, and the done state settles the choice
// and writes the room back. The table holds busy-until time and booking count
// per room in a synchronous memory; per-room valid flags make it read as zero
// after reset, so no clearing pass is needed. Requests must arrive in rising
// start order. A request whose end is not after its start comes back flagged
// and changes nothing. The result sits in an output register, so a new item
// is taken as soon as the previous one has been written back, even if its
// result has not been collected. The user must write rooms_in_use through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module room_dispatch_scheduler_unit (
  input  logic                        clk,
  input  logic                        rst,
  rds_req_if.sink                     req,
  rds_res_if.source                   res,
  input  logic                        cfg_we,
  input  logic [rds_pkg::CFG_W-1:0]   cfg_wdata
);

  // room table, read once per cycle and written at most once per cycle
  logic [rds_pkg::END_W-1:0] busy_mem [rds_pkg::ROOMS];
  logic [rds_pkg::CNT_W-1:0] cnt_mem  [rds_pkg::ROOMS];
  logic [rds_pkg::ROOMS-1:0] ent_vld;

  logic [rds_pkg::ROOM_W-1:0] rd_addr;
  logic [rds_pkg::END_W-1:0]  rd_busy;
  logic [rds_pkg::CNT_W-1:0]  rd_cnt;
  logic                       rd_vld;
  logic [rds_pkg::END_W-1:0]  cur_busy;
  logic [rds_pkg::CNT_W-1:0]  cur_cnt;

  // control
  rds_pkg::state_t state, state_next;
  logic [rds_pkg::CFG_W-1:0]  rooms_in_use;
  logic [rds_pkg::NUM_W-1:0]  n_cur;
  logic [rds_pkg::NUM_W-1:0]  n_clamp;
  logic [rds_pkg::ROOM_W-1:0] idx;
  logic                       scan_last;
  logic                       accept;
  logic                       done_go;
  logic                       out_vld;

  // request held for the scan
  logic [rds_pkg::TIME_W-1:0] s_reg;
  logic [rds_pkg::TIME_W-1:0] e_reg;
  logic                       bad_reg;

  // scan accumulators
  logic                       found;
  logic [rds_pkg::ROOM_W-1:0] free_room;
  logic [rds_pkg::CNT_W-1:0]  free_cnt;
  logic [rds_pkg::END_W-1:0]  min_bu;
  logic [rds_pkg::ROOM_W-1:0] min_room;
  logic [rds_pkg::CNT_W-1:0]  min_cnt;
  logic [rds_pkg::CNT_W-1:0]  max_cnt;
  logic [rds_pkg::ROOM_W-1:0] max_room;

  // decision
  logic [rds_pkg::ROOM_W-1:0] sel_room;
  logic [rds_pkg::CNT_W-1:0]  sel_cnt;
  logic [rds_pkg::CNT_W-1:0]  new_cnt;
  logic [rds_pkg::TIME_W-1:0] dur;
  logic [rds_pkg::END_W:0]    late_sum;
  logic [rds_pkg::END_W-1:0]  fin;
  logic [rds_pkg::ROOM_W-1:0] top_room;

  // output register
  logic [rds_pkg::FIELD_ROOM_W-1:0] o_room;
  logic [rds_pkg::END_W-1:0]        o_end;
  logic                             o_delayed;
  logic [rds_pkg::FIELD_ROOM_W-1:0] o_top;
  logic                             o_bad;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      rooms_in_use <= rds_pkg::ROOMS_RESET;
    end else if (cfg_we) begin
      rooms_in_use <= cfg_wdata;
    end
  end

  // zero acts as one, anything past the table acts as the full table
  always_comb begin
    if (rooms_in_use == '0) begin
      n_clamp = rds_pkg::NUM_W'(1);
    end else if (32'(rooms_in_use) > rds_pkg::ROOMS) begin
      n_clamp = rds_pkg::NUM_W'(rds_pkg::ROOMS);
    end else begin
      n_clamp = rds_pkg::NUM_W'(rooms_in_use);
    end
  end

  // ---------------------------------------------------------------- state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign scan_last = (rds_pkg::NUM_W'(idx) == n_cur - rds_pkg::NUM_W'(1));

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    done_go    = 1'b0;
    rd_addr    = '0;
    case (state)
      rds_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        rd_addr   = '0;
        if (req.valid) begin
          state_next = rds_pkg::ST_SCAN;
        end
      end
      rds_pkg::ST_SCAN: begin
        rd_addr = idx + rds_pkg::ROOM_W'(1);
        if (scan_last) begin
          state_next = rds_pkg::ST_DONE;
        end
      end
      rds_pkg::ST_DONE: begin
        // wait only while an older result is still unclaimed
        if (!out_vld || res.ready) begin
          done_go    = 1'b1;
          state_next = rds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rds_pkg::ST_IDLE;
      end
    endcase
  end

  assign accept = req.valid && req.ready;

  // ---------------------------------------------------------------- room table
  always_ff @(posedge clk) begin
    if (done_go && !bad_reg) begin
      busy_mem[sel_room] <= fin;
      cnt_mem[sel_room]  <= new_cnt;
    end
    rd_busy <= busy_mem[rd_addr];
    rd_cnt  <= cnt_mem[rd_addr];
    rd_vld  <= ent_vld[rd_addr];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else if (done_go && !bad_reg) begin
      ent_vld[sel_room] <= 1'b1;
    end
  end

  assign cur_busy = rd_vld ? rd_busy : '0;
  assign cur_cnt  = rd_vld ? rd_cnt  : '0;

  // ---------------------------------------------------------------- scan
  always_ff @(posedge clk) begin
    if (accept) begin
      s_reg   <= req.start_time;
      e_reg   <= req.end_time;
      bad_reg <= (req.end_time <= req.start_time);
      n_cur   <= n_clamp;
      idx     <= '0;
    end else if (state == rds_pkg::ST_SCAN) begin
      idx <= idx + rds_pkg::ROOM_W'(1);
      if (idx == '0) begin
        // first room seeds every running choice
        found     <= (cur_busy <= rds_pkg::END_W'(s_reg));
        free_room <= '0;
        free_cnt  <= cur_cnt;
        min_bu    <= cur_busy;
        min_room  <= '0;
        min_cnt   <= cur_cnt;
        max_cnt   <= cur_cnt;
        max_room  <= '0;
      end else begin
        // lowest free room wins
        if (!found && (cur_busy <= rds_pkg::END_W'(s_reg))) begin
          found     <= 1'b1;
          free_room <= idx;
          free_cnt  <= cur_cnt;
        end
        // earliest to free up, strict so ties keep the lower index
        if (cur_busy < min_bu) begin
          min_bu   <= cur_busy;
          min_room <= idx;
          min_cnt  <= cur_cnt;
        end
        if (cur_cnt > max_cnt) begin
          max_cnt  <= cur_cnt;
          max_room <= idx;
        end
      end
    end
  end

  // ---------------------------------------------------------------- decision
  assign sel_room = found ? free_room : min_room;
  assign sel_cnt  = found ? free_cnt  : min_cnt;
  assign new_cnt  = (sel_cnt == rds_pkg::COUNT_MAX) ? sel_cnt
                                                    : sel_cnt + rds_pkg::CNT_W'(1);
  assign dur      = e_reg - s_reg;
  assign late_sum = {1'b0, min_bu} + (rds_pkg::END_W + 1)'(dur);

  always_comb begin
    if (found) begin
      fin = rds_pkg::END_W'(e_reg);
    end else if (late_sum[rds_pkg::END_W]) begin
      fin = rds_pkg::END_MAX;  // saturate
    end else begin
      fin = late_sum[rds_pkg::END_W-1:0];
    end
  end

  // only the booked room changes count, so compare it against the old leader
  always_comb begin
    top_room = max_room;
    if (!bad_reg) begin
      if ((new_cnt > max_cnt) || ((new_cnt == max_cnt) && (sel_room < max_room))) begin
        top_room = sel_room;
      end
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (done_go) begin
      out_vld <= 1'b1;
    end else if (res.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      o_bad <= bad_reg;
      o_top <= rds_pkg::FIELD_ROOM_W'(top_room);
      if (bad_reg) begin
        o_room    <= '0;
        o_end     <= '0;
        o_delayed <= 1'b0;
      end else begin
        o_room    <= rds_pkg::FIELD_ROOM_W'(sel_room);
        o_end     <= fin;
        o_delayed <= !found;
      end
    end
  end

  assign res.valid            = out_vld;
  assign res.assigned_room    = o_room;
  assign res.actual_end       = o_end;
  assign res.was_delayed      = o_delayed;
  assign res.most_booked_room = o_top;
  assign res.bad_request      = o_bad;

endmodule

// File: rtl/rds_checker.sv
// ----------------------------------------------------------------------------
// rds_checker
// port-level checks on the room dispatch scheduler, bound to the top level
// ----------------------------------------------------------------------------
`include "room_dispatch_scheduler_unit_assert.svh"

module rds_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               res_valid,
  input logic                               res_ready,
  input logic [rds_pkg::FIELD_ROOM_W-1:0]   res_room,
  input logic [rds_pkg::END_W-1:0]          res_end,
  input logic                               res_delayed,
  input logic                               res_bad
);

  // a held result stays offered
  `RDS_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)

  // one item in the table walk at a time
  `RDS_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_valid && req_ready, !req_ready)

  // a rejected request carries no booking
  `RDS_ASSERT_IMP(a_bad_empty, clk, rst, res_valid && res_bad,
                  res_room == '0 && res_end == '0 && !res_delayed)

  // a real booking always ends after time zero
  `RDS_ASSERT_IMP(a_end_nonzero, clk, rst, res_valid && !res_bad, res_end != '0)

endmodule

bind room_dispatch_scheduler_unit rds_checker u_rds_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_room    (res.assigned_room),
  .res_end     (res.actual_end),
  .res_delayed (res.was_delayed),
  .res_bad     (res.bad_request)
);

// File: sim/rds_booking_checker.sv
// ----------------------------------------------------------------------------
// rds_booking_checker
// watches the request, result and room-count ports of the room dispatch
// scheduler, predicts every result from its own copy of the room table and
// compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module rds_booking_checker
  import rds_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  rds_req_if               req,
  rds_res_if               res,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int unsigned      pending,
  output int unsigned      fails
);

  typedef struct packed {
    logic [FIELD_ROOM_W-1:0] assigned_room;
    logic [END_W-1:0]        actual_end;
    logic                    was_delayed;
    logic [FIELD_ROOM_W-1:0] most_booked_room;
    logic                    bad_request;
  } booking_t;

  // own copy of the room table and of the room count
  logic [END_W-1:0] free_at  [ROOMS];
  logic [CNT_W-1:0] bookings [ROOMS];
  logic [CFG_W-1:0] rooms_cfg;

  booking_t    booked_results[$];
  int unsigned result_no;

  // one line per mismatch, and count it
  task automatic flag_mismatch(input string what, input logic [END_W-1:0] got,
                               input logic [END_W-1:0] want);
    $display("mismatch: result %0d %s: got %0h want %0h", result_no, what, got, want);
    fails++;
  endtask

  function automatic int unsigned live_rooms();
    int unsigned n;
    n = rooms_cfg;
    if (n == 0) n = 1;
    if (n > ROOMS) n = ROOMS;
    return n;
  endfunction

  function automatic int unsigned busiest_room(input int unsigned n);
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < n; i++) begin
      if (bookings[i] > bookings[best]) best = i;
    end
    return best;
  endfunction

  function automatic booking_t place_booking(input logic [TIME_W-1:0] s,
                                             input logic [TIME_W-1:0] e);
    booking_t         r;
    int unsigned      n;
    int unsigned      pick;
    logic             hit;
    logic [END_W-1:0] span;
    n = live_rooms();
    r = '0;
    if (e <= s) begin
      r.most_booked_room = FIELD_ROOM_W'(busiest_room(n));
      r.bad_request      = 1'b1;
      return r;
    end
    hit  = 1'b0;
    pick = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (!hit && free_at[i] <= END_W'(s)) begin
        pick = i;
        hit  = 1'b1;
      end
    end
    if (hit) begin
      r.actual_end = END_W'(e);
    end else begin
      // every room busy: take the earliest to free, push the booking back
      span = END_W'(e - s);
      pick = 0;
      for (int unsigned i = 1; i < n; i++) begin
        if (free_at[i] < free_at[pick]) pick = i;
      end
      if (free_at[pick] > END_MAX - span) r.actual_end = END_MAX;
      else r.actual_end = free_at[pick] + span;
      r.was_delayed = 1'b1;
    end
    free_at[pick] = r.actual_end;
    if (bookings[pick] != COUNT_MAX) bookings[pick] = bookings[pick] + CNT_W'(1);
    r.assigned_room    = FIELD_ROOM_W'(pick);
    r.most_booked_room = FIELD_ROOM_W'(busiest_room(n));
    return r;
  endfunction

  always @(posedge clk) begin
    booking_t want;
    if (rst) begin
      for (int i = 0; i < ROOMS; i++) begin
        free_at[i]  = '0;
        bookings[i] = '0;
      end
      rooms_cfg = ROOMS_RESET;
      booked_results.delete();
      result_no = 0;
    end else begin
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        if (booked_results.size() == 0) begin
          flag_mismatch("with no request waiting", '0, '0);
        end else begin
          want = booked_results.pop_front();
          if (res.assigned_room !== want.assigned_room)
            flag_mismatch("assigned_room", END_W'(res.assigned_room),
                          END_W'(want.assigned_room));
          if (res.actual_end !== want.actual_end)
            flag_mismatch("actual_end", res.actual_end, want.actual_end);
          if (res.was_delayed !== want.was_delayed)
            flag_mismatch("was_delayed", END_W'(res.was_delayed),
                          END_W'(want.was_delayed));
          if (res.most_booked_room !== want.most_booked_room)
            flag_mismatch("most_booked_room", END_W'(res.most_booked_room),
                          END_W'(want.most_booked_room));
          if (res.bad_request !== want.bad_request)
            flag_mismatch("bad_request", END_W'(res.bad_request),
                          END_W'(want.bad_request));
        end
        result_no++;
      end
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        booked_results.push_back(place_booking(req.start_time, req.end_time));
      end
      if (cfg_we === 1'b1) rooms_cfg = cfg_wdata;
    end
    pending = booked_results.size();
  end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives booking requests and room-count settings into the room dispatch
// scheduler with random idling on both channels; a checker beside the block
// predicts and compares every result, and this module gives the verdict
// ----------------------------------------------------------------------------
module tb;
  import rds_pkg::*;

  // generous bound on the whole run, several times the slowest correct run
  localparam int RUN_LIMIT   = 1_000_000;
  localparam int PHASE_ITEMS = 62;
  // a few back-to-back maximum bookings on one room, stacking its end time
  // well past the 32-bit range
  localparam int FILL_ITEMS  = 6;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int unsigned      pending;
  int unsigned      fails;
  // when set, neither side idles
  bit               steady;

  // room counts of the random phases: clamped values and both extremes
  logic [CFG_W-1:0] phase_rooms [12] = '{16, 3, 1, 8, 0, 5, 31, 2, 12, 17, 4, 16};

  rds_req_if req ();
  rds_res_if res ();

  room_dispatch_scheduler_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rds_booking_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pending   (pending),
    .fails     (fails)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // offer one booking item; entered and left at a falling edge
  task automatic offer_booking(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.start_time <= s;
    req.end_time   <= e;
    // the item goes in at the first rising edge that sees ready
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  // change the room count only once every booked result is back
  task automatic set_room_count(input logic [CFG_W-1:0] v);
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // result side: random stall before every item, ready held until it is taken
  initial begin
    int unsigned gap;
    res.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
      while (res.valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    logic [TIME_W-1:0] cursor;
    logic [TIME_W-1:0] s;
    logic [TIME_W-1:0] e;
    int unsigned       live;
    int unsigned       roll;

    rst            = 1'b1;
    steady         = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req.valid      = 1'b0;
    req.start_time = '0;
    req.end_time   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed part ----
    // reset room count of 16: plain placement and the flagged requests
    offer_booking(32'd0, 32'd1);
    offer_booking(32'd0, 32'd9);
    offer_booking(32'd5, 32'd5);                  // end equal to start
    offer_booking(32'd6, 32'd2);                  // end below start
    offer_booking(32'hFFFF_FFFF, 32'hFFFF_FFFF);  // start at its top, still flagged
    offer_booking(32'hFFFF_FFFF, 32'd0);

    // two rooms: waiting, earliest-free ties, out-of-order start
    set_room_count(5'd2);
    offer_booking(32'd2, 32'd12);
    offer_booking(32'd3, 32'd6);                  // both busy, pushed back
    offer_booking(32'd4, 32'd5);                  // tie on free time, lowest room
    offer_booking(32'd1, 32'd3);                  // start goes backwards
    offer_booking(32'd13, 32'd20);                // room frees exactly at start

    // zero rooms behaves as one
    set_room_count(5'd0);
    offer_booking(32'd14, 32'd15);
    offer_booking(32'd30, 32'd40);
    offer_booking(32'd8, 32'd8);                  // flagged, busiest of one room

    // count above the room total behaves as all rooms; dropped rooms kept state
    set_room_count(5'd31);
    offer_booking(32'd40, 32'd41);
    offer_booking(32'd40, 32'd50);
    offer_booking(32'd40, 32'd41);
    offer_booking(32'd0, 32'd1);

    set_room_count(5'd1);
    offer_booking(32'd41, 32'd43);
    offer_booking(32'd41, 32'd42);

    // ---- random part ----
    // each phase starts higher up the time line so old bookings have lapsed
    for (int p = 0; p < 12; p++) begin
      set_room_count(phase_rooms[p]);
      live   = (phase_rooms[p] == 0) ? 1 :
               ((phase_rooms[p] > ROOMS) ? ROOMS : phase_rooms[p]);
      steady = (p == 3 || p == 9);
      cursor = (p + 1) * 32'h1300_0000 + $urandom_range(0, 32'h00FF_FFFF);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        roll   = $urandom_range(0, 99);
        cursor = cursor + $urandom_range(0, 12);
        // now and then a long quiet spell
        if ($urandom_range(0, 99) == 0) cursor = cursor + $urandom_range(0, 32'h0001_0000);
        s = cursor;
        if (roll < 3) s = cursor - $urandom_range(1, 64);
        if (roll >= 3 && roll < 8) begin
          // flagged: end at or before start
          e = s - $urandom_range(0, 15);
        end else if (roll < 92) begin
          // short bookings keep the rooms contended
          e = s + $urandom_range(1, 8 * live);
        end else if (roll < 99) begin
          e = s + $urandom_range(1, 4096);
        end else begin
          e = s + $urandom_range(1, 32'h0010_0000);
        end
        offer_booking(s, e);
      end
    end
    steady = 1'b0;

    // ---- long bookings ----
    // one room, no idling: a booking to the top of the range, then maximum
    // length bookings that stack the end time beyond 32 bits
    set_room_count(5'd1);
    steady = 1'b1;
    offer_booking(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    for (int k = 0; k < FILL_ITEMS; k++) begin
      offer_booking(32'd0, 32'hFFFF_FFFF);
    end
    offer_booking(32'd3, 32'd3);
    req.valid <= 1'b0;

    // drain, then a short tail to catch any stray result
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/rds_pkg.sv
rtl/rds_if.sv
rtl/room_dispatch_scheduler_unit.sv
rtl/rds_checker.sv
sim/rds_booking_checker.sv
sim/tb.sv
